[rtl/core/vector_similarity_scorer_defines.svh]
// Assertion macros for the similarity scorer checker
`ifndef VECTOR_SIMILARITY_SCORER_DEFINES_SVH
`define VECTOR_SIMILARITY_SCORER_DEFINES_SVH

`define VSS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define VSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[rtl/core/vss_pkg.sv]
`timescale 1ns / 1ps
package vss_pkg;
    localparam int DEF_MAX_DIM     = 64;
    localparam int DEF_VALUE_WIDTH = 16;
    localparam int ELEM_W  = 16;
    localparam int SCORE_W = 48;
    localparam int CNT_W   = 7;
    localparam int DOT_W   = 40;
    localparam int DIFF_W  = 41;
    localparam int REG_IDX_W = 2;

    localparam logic [REG_IDX_W-1:0] REG_METRIC = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_DIM    = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_INV    = 2'd2;

    localparam logic [1:0] METRIC_COS = 2'd0;
    localparam logic [1:0] METRIC_L2  = 2'd1;

    localparam logic OP_REF_WRITE = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC,
        ST_SQRT,
        ST_MUL,
        ST_DIV,
        ST_OUT
    } state_t;

    // row accumulator results handed to the finishing unit
    typedef struct packed {
        logic signed [DOT_W-1:0]  dot;
        logic        [DOT_W-1:0]  row_sq;
        logic        [DIFF_W-1:0] diff_sq;
        logic                     bad;
    } row_sum_t;
endpackage

[rtl/core/vector_similarity_scorer.sv]
`timescale 1ns / 1ps
// channel | dir | handshake     | beat carries
// in      | in  | valid/stall   | operation, ref_index, elem_value, elem_null, row_last
// out     | out | valid/stall   | score, bad_dims
// cfg     | in  | valid/ready   | cfg_index, cfg_data
// Each accepted reference write or row element stalls input behind it; a row element
// is read from memory, then multiply-accumulated. A last element stalls input while
// scoring: dot or bad dimensions go straight out, L2 takes a root (one root bit per
// cycle), cosine a root, a multiply and a 128-step divider, and cosine with a zero
// row norm skips the divider. Reset clears counter, accumulators and the scoring
// sequencer; reference memory is not cleared. A stalled result holds the block.
module vector_similarity_scorer
    import vss_pkg::*;
#(
    parameter int MAX_DIM     = DEF_MAX_DIM,
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 operation,
    input  logic [5:0]           ref_index,
    input  logic signed [ELEM_W-1:0] elem_value,
    input  logic                 elem_null,
    input  logic                 row_last,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic signed [SCORE_W-1:0] score,
    output logic                 bad_dims,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);
    logic [1:0] metric_reg;
    logic [CNT_W-1:0] dim_reg;
    logic [31:0] inv_reg;
    logic busy_reg;
    logic acc_busy;
    logic accept, done, fin_busy, fin_start;
    row_sum_t sums;
    logic [SCORE_W-1:0] sc;

    assign cfg_ready = 1'b1;
    assign in_stall  = busy_reg || fin_busy || done;
    assign accept    = in_valid && !in_stall;
    assign fin_start = done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            metric_reg <= '0;
            dim_reg    <= '0;
            inv_reg    <= '0;
            busy_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_METRIC: metric_reg <= cfg_data[1:0];
                    REG_DIM:    dim_reg    <= cfg_data[CNT_W-1:0];
                    REG_INV:    inv_reg    <= cfg_data;
                    default:    ;
                endcase
            end
            busy_reg <= accept;
        end
    end

    assign acc_busy = busy_reg;

    vss_accum #(.MAX_DIM(MAX_DIM), .VALUE_WIDTH(VALUE_WIDTH)) u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (accept && operation == OP_REF_WRITE),
        .wr_idx    (ref_index),
        .wr_value  (elem_value),
        .row_en    (accept && operation != OP_REF_WRITE),
        .row_value (elem_value),
        .row_null  (elem_null),
        .row_last  (row_last),
        .dim_count (dim_reg),
        .done      (done),
        .sums      (sums)
    );

    vss_finish u_finish (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (fin_start && !acc_busy),
        .sums       (sums),
        .metric     (metric_reg),
        .norm_recip (inv_reg),
        .busy       (fin_busy),
        .res_valid  (out_valid),
        .res_stall  (out_stall),
        .res_score  (sc),
        .res_bad    (bad_dims)
    );

    assign score = sc;
endmodule

[rtl/core/vss_accum.sv]
`timescale 1ns / 1ps
module vss_accum
    import vss_pkg::*;
#(
    parameter int MAX_DIM     = DEF_MAX_DIM,
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic [5:0]           wr_idx,
    input  logic [ELEM_W-1:0]    wr_value,
    input  logic                 row_en,
    input  logic [ELEM_W-1:0]    row_value,
    input  logic                 row_null,
    input  logic                 row_last,
    input  logic [CNT_W-1:0]     dim_count,
    output logic                 done,
    output row_sum_t             sums
);
    localparam int VW    = (VALUE_WIDTH < 16) ? VALUE_WIDTH : 16;
    localparam int ADDR_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

    logic signed [ELEM_W-1:0] ref_mem [MAX_DIM];
    logic signed [ELEM_W-1:0] rd_data_reg;

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic signed [DOT_W-1:0] dot_reg, dot_next;
    logic [DOT_W-1:0] rsq_reg, rsq_next;
    logic [DIFF_W-1:0] dsq_reg, dsq_next;
    logic stage_reg, use_reg, last_reg;
    logic [CNT_W-1:0] cnt_s_reg;
    logic signed [ELEM_W-1:0] val_reg;
    logic done_reg;
    row_sum_t sums_reg;

    logic signed [ELEM_W-1:0] val_ext;
    logic [CNT_W-1:0] rd_ptr;
    logic signed [ELEM_W:0] diff;
    logic signed [2*ELEM_W-1:0] p_dot, p_rsq;
    logic signed [2*ELEM_W+1:0] p_dsq;
    logic [CNT_W-1:0] cnt_sat;
    logic bad;
    logic signed [DOT_W-1:0] dot_sum;
    logic [DOT_W-1:0] rsq_sum;
    logic [DIFF_W-1:0] dsq_sum;

    function automatic logic signed [ELEM_W-1:0] sext(input logic [ELEM_W-1:0] raw);
        logic [ELEM_W-1:0] r;
        r = raw;
        for (int i = 0; i < ELEM_W; i++)
        begin
            if (i >= VW)
            begin
                r[i] = raw[VW-1];
            end
        end
        return r;
    endfunction

    assign val_ext = row_null ? '0 : sext(row_value);
    assign rd_ptr  = cnt_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en && ({26'd0, wr_idx} < 32'(MAX_DIM)))
        begin
            ref_mem[wr_idx[ADDR_W-1:0]] <= sext(wr_value);
        end
        rd_data_reg <= ref_mem[rd_ptr[ADDR_W-1:0]];
    end

    assign diff  = {val_reg[ELEM_W-1], val_reg} - {rd_data_reg[ELEM_W-1], rd_data_reg};
    assign p_dot = val_reg * rd_data_reg;
    assign p_rsq = val_reg * val_reg;
    assign p_dsq = diff * diff;
    assign cnt_sat = (cnt_s_reg < 7'd127) ? cnt_s_reg + 7'd1 : 7'd127;

    always_comb
    begin
        dot_sum = dot_reg;
        rsq_sum = rsq_reg;
        dsq_sum = dsq_reg;
        cnt_next = cnt_reg;
        if (row_en)
        begin
            cnt_next = (cnt_reg < 7'd127) ? cnt_reg + 7'd1 : 7'd127;
        end
        if (stage_reg && use_reg)
        begin
            dot_sum = dot_reg + DOT_W'(p_dot);
            rsq_sum = rsq_reg + DOT_W'(unsigned'(p_rsq));
            dsq_sum = dsq_reg + DIFF_W'(unsigned'(p_dsq));
        end
        dot_next = dot_sum;
        rsq_next = rsq_sum;
        dsq_next = dsq_sum;
        if (stage_reg && last_reg)
        begin
            dot_next = '0;
            rsq_next = '0;
            dsq_next = '0;
            cnt_next = '0;
        end
    end

    assign bad = (dim_count == '0) || ({25'd0, dim_count} > 32'(MAX_DIM)) ||
                 (cnt_sat != dim_count);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            dot_reg   <= '0;
            rsq_reg   <= '0;
            dsq_reg   <= '0;
            stage_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg   <= cnt_next;
            dot_reg   <= dot_next;
            rsq_reg   <= rsq_next;
            dsq_reg   <= dsq_next;
            stage_reg <= row_en;
            done_reg  <= stage_reg && last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (row_en)
        begin
            val_reg   <= val_ext;
            use_reg   <= (cnt_reg < dim_count) && ({25'd0, cnt_reg} < 32'(MAX_DIM));
            last_reg  <= row_last;
            cnt_s_reg <= cnt_reg;
        end
        if (stage_reg && last_reg)
        begin
            sums_reg.dot     <= dot_sum;
            sums_reg.row_sq  <= rsq_sum;
            sums_reg.diff_sq <= dsq_sum;
            sums_reg.bad     <= bad;
        end
    end

    assign done = done_reg;
    assign sums = sums_reg;
endmodule

[rtl/core/vss_finish.sv]
`timescale 1ns / 1ps
module vss_finish
    import vss_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  row_sum_t             sums,
    input  logic [1:0]           metric,
    input  logic [31:0]          norm_recip,
    output logic                 busy,
    output logic                 res_valid,
    input  logic                 res_stall,
    output logic [SCORE_W-1:0]   res_score,
    output logic                 res_bad
);
    localparam int RAD_W = 64;
    localparam int ROOT_W = 32;
    localparam int PROD_W = 72;
    localparam int NUM_W  = 128;
    localparam logic [63:0] SMAX = 64'h0000_7FFF_FFFF_FFFF;

    state_t state_reg, state_next;
    logic [RAD_W-1:0] rad_reg;
    logic [RAD_W+1:0] rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [5:0] step_reg;
    logic [1:0] metric_reg;
    logic neg_reg;
    logic [DOT_W-1:0] mag_reg;
    logic [31:0] inv_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [64:0] drem_reg;
    logic [6:0] bit_reg;
    logic [SCORE_W-1:0] score_reg;
    logic bad_reg;

    logic [RAD_W+1:0] trial;
    logic [RAD_W+1:0] rem_sh;
    logic [64:0] dsh;

    assign rem_sh = {rem_reg[RAD_W-1:0], rad_reg[RAD_W-1:RAD_W-2]};
    assign trial  = {32'd0, root_reg, 2'b01};
    assign dsh    = {drem_reg[63:0], quo_reg[NUM_W-1]};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (sums.bad || (metric != METRIC_COS && metric != METRIC_L2))
                    begin
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        state_next = ST_SQRT;
                    end
                end
            end
            ST_SQRT:
            begin
                if (step_reg == 6'd31)
                begin
                    state_next = (metric_reg == METRIC_COS) ? ST_MUL : ST_OUT;
                end
            end
            ST_MUL:
            begin
                state_next = (root_reg == '0) ? ST_OUT : ST_DIV;
            end
            ST_DIV:
            begin
                if (bit_reg == 7'd127)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!res_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        busy      = (state_reg != ST_IDLE);
        res_valid = (state_reg == ST_OUT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                metric_reg <= metric;
                inv_reg    <= norm_recip;
                bad_reg    <= sums.bad;
                neg_reg    <= sums.dot[DOT_W-1];
                mag_reg    <= sums.dot[DOT_W-1] ? DOT_W'(-sums.dot) : sums.dot;
                rem_reg    <= '0;
                root_reg   <= '0;
                step_reg   <= '0;
                rad_reg    <= (metric == METRIC_COS) ? {8'd0, sums.row_sq, 16'd0}
                                                     : {7'd0, sums.diff_sq, 16'd0};
                if (sums.bad)
                begin
                    score_reg <= '0;
                end
                else
                begin
                    score_reg <= SCORE_W'(sums.dot);
                end
            end
            ST_SQRT:
            begin
                step_reg <= step_reg + 6'd1;
                rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
                if (rem_sh >= trial)
                begin
                    rem_reg  <= rem_sh - trial;
                    root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= rem_sh;
                    root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
                end
                if (step_reg == 6'd31)
                begin
                    score_reg <= SCORE_W'({root_reg[ROOT_W-2:0], rem_sh >= trial});
                end
            end
            ST_MUL:
            begin
                prod_reg  <= PROD_W'(mag_reg) * PROD_W'(inv_reg);
                quo_reg   <= '0;
                drem_reg  <= '0;
                bit_reg   <= '0;
                score_reg <= '0;
            end
            ST_DIV:
            begin
                if (bit_reg == 7'd0)
                begin
                    // top numerator bit is zero, so the first step only shifts
                    quo_reg <= {55'd0, prod_reg, 1'b0};
                end
                else
                begin
                    if (dsh >= {33'd0, root_reg})
                    begin
                        drem_reg <= dsh - {33'd0, root_reg};
                        quo_reg  <= {quo_reg[NUM_W-2:0], 1'b1};
                    end
                    else
                    begin
                        drem_reg <= dsh;
                        quo_reg  <= {quo_reg[NUM_W-2:0], 1'b0};
                    end
                end
                bit_reg <= bit_reg + 7'd1;
            end
            ST_OUT:
            begin
                if (metric_reg == METRIC_COS && !bad_reg && root_reg != '0 &&
                    bit_reg == 7'd0)
                begin
                    // last quotient bit settled on the final divide step
                    bit_reg <= 7'd1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // final divide bit folded in combinationally, then registered on the last divide step
    logic [NUM_W-1:0] quo_fin;
    always_comb
    begin
        quo_fin = (dsh >= {33'd0, root_reg}) ? {quo_reg[NUM_W-2:0], 1'b1}
                                             : {quo_reg[NUM_W-2:0], 1'b0};
    end

    logic div_path;
    logic [NUM_W-1:0] quo_out_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_path <= 1'b0;
        end
        else if (state_reg == ST_DIV && bit_reg == 7'd127)
        begin
            div_path <= 1'b1;
        end
        else if (state_reg == ST_IDLE)
        begin
            div_path <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DIV && bit_reg == 7'd127)
        begin
            quo_out_reg <= quo_fin;
        end
    end

    logic [SCORE_W-1:0] cos_score;
    logic [63:0] qm;
    always_comb
    begin
        qm = quo_out_reg[63:0];
        if (quo_out_reg[NUM_W-1:64] != '0 || qm > SMAX)
        begin
            qm = SMAX;
        end
        cos_score = neg_reg ? SCORE_W'(-qm) : SCORE_W'(qm);
    end

    assign res_score = div_path ? cos_score : score_reg;
    assign res_bad   = bad_reg;
endmodule

[rtl/core/vss_checker.sv]
`timescale 1ns / 1ps
`include "vector_similarity_scorer_defines.svh"
module vss_checker
    import vss_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_stall,
    input logic out_valid,
    input logic out_stall,
    input logic bad_dims,
    input logic [SCORE_W-1:0] score
);
    `VSS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
    `VSS_ASSERT_IMPL(a_bad_zero, clk, rst_n, out_valid && bad_dims, score == '0)
    `VSS_ASSERT_IMPL(a_no_take_busy, clk, rst_n, out_valid, in_stall)
    `VSS_ASSERT_NEXT(a_score_hold, clk, rst_n, out_valid && out_stall, $stable(score))
    `VSS_ASSERT_NEXT(a_in_hold, clk, rst_n, in_valid && in_stall, in_valid)
endmodule

bind vector_similarity_scorer vss_checker u_vss_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .bad_dims  (bad_dims),
    .score     (score)
);
